>>> hdl/mcmu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcmu_pkg
// Shared types and constants for the lock and condition-variable manager.
// ----------------------------------------------------------------------------
package mcmu_pkg;

    localparam int MAX_THREADS = 16;
    localparam int NUM_LOCKS   = 4;
    localparam int NUM_CONDS   = 4;

    localparam int TID_W  = 4;
    localparam int LOCK_W = 2;
    localparam int COND_W = 2;
    localparam int PTR_W  = $clog2(MAX_THREADS);
    localparam int CNT_W  = $clog2(MAX_THREADS + 1);
    localparam int LQ_W   = $clog2(NUM_LOCKS * MAX_THREADS);
    localparam int CQ_W   = $clog2(NUM_CONDS * MAX_THREADS);

    localparam logic [2:0] CMD_ACQUIRE   = 3'd0;
    localparam logic [2:0] CMD_RELEASE   = 3'd1;
    localparam logic [2:0] CMD_WAIT      = 3'd2;
    localparam logic [2:0] CMD_SIGNAL    = 3'd3;
    localparam logic [2:0] CMD_BROADCAST = 3'd4;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_HELD     = 3'd1;
    localparam logic [2:0] ST_BLOCKED  = 3'd2;
    localparam logic [2:0] ST_DONE     = 3'd3;
    localparam logic [2:0] ST_NOTOWNER = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;
    localparam logic [2:0] ST_NONE     = 3'd7;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [TID_W-1:0]  tid;
        logic [LOCK_W-1:0] lck;
        logic [COND_W-1:0] cnd;
    } req_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request, start queue head reads
        logic exec;    // apply one step, build result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic more;    // broadcast needs another step
    } dp_stat_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             handed_valid;
        logic [TID_W-1:0] handed_thread;
        logic             moved_valid;
        logic [TID_W-1:0] moved_thread;
        logic             last;
    } res_t;

endpackage
`default_nettype wire

>>> hdl/mcmu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcmu_datapath
// Lock and condition state, waiter queue memories and result building.
// ----------------------------------------------------------------------------
module mcmu_datapath
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  mcmu_pkg::req_t        req,
    input  mcmu_pkg::dp_cmd_t     cmd,
    output mcmu_pkg::dp_stat_t    stat,
    output mcmu_pkg::res_t        res
);

    localparam int TW = mcmu_pkg::TID_W;
    localparam int PW = mcmu_pkg::PTR_W;
    localparam int CW = mcmu_pkg::CNT_W;
    localparam int NL = mcmu_pkg::NUM_LOCKS;
    localparam int NC = mcmu_pkg::NUM_CONDS;

    logic [TW-1:0] lq_mem [NL*mcmu_pkg::MAX_THREADS];
    logic [TW-1:0] cq_mem [NC*mcmu_pkg::MAX_THREADS];

    logic [NL-1:0] busy_reg;
    logic [TW-1:0] owner_reg [NL];
    logic [PW-1:0] lhead_reg [NL];
    logic [PW-1:0] ltail_reg [NL];
    logic [CW-1:0] lcnt_reg  [NL];
    logic [PW-1:0] chead_reg [NC];
    logic [PW-1:0] ctail_reg [NC];
    logic [CW-1:0] ccnt_reg  [NC];
    logic [NC-1:0] bvalid_reg;
    logic [mcmu_pkg::LOCK_W-1:0] block_reg [NC];

    mcmu_pkg::req_t req_reg;
    logic           first_reg;
    logic [TW-1:0]  lrd_reg, crd_reg;
    mcmu_pkg::res_t res_reg, res_next;
    logic           more_next;

    // index reads for the current request
    logic [mcmu_pkg::LOCK_W-1:0] l;
    logic [mcmu_pkg::COND_W-1:0] c;
    assign l = req_reg.lck;
    assign c = req_reg.cnd;

    logic [mcmu_pkg::LQ_W-1:0] lrd_addr, lwr_addr;
    logic [mcmu_pkg::CQ_W-1:0] crd_addr, cwr_addr;
    logic                      lwr_en, cwr_en, lpop, cpop;
    logic [TW-1:0]             lwr_data, cwr_data;
    logic                      owns, t_owns, full_l;
    logic                      rel_hand, do_rel, do_bind, do_unbind;
    logic                      set_busy, cnt_c_last;

    // queue heads are read from the request being loaded, and again on each execute step
    always_ff @(posedge clk)
    begin
        if (cmd.load | cmd.exec)
        begin
            lrd_reg <= lq_mem[lrd_addr];
            crd_reg <= cq_mem[crd_addr];
        end
        if (lwr_en)
            lq_mem[lwr_addr] <= lwr_data;
        if (cwr_en)
            cq_mem[cwr_addr] <= cwr_data;
    end

    always_comb
    begin
        if (cmd.load)
        begin
            lrd_addr = {req.lck, lhead_reg[req.lck]};
            crd_addr = {req.cnd, chead_reg[req.cnd]};
        end
        else
        begin
            // broadcast: next condition head after a pop
            lrd_addr = {l, lhead_reg[l]};
            crd_addr = {c, chead_reg[c] + PW'(1)};
        end
    end

    always_comb
    begin
        owns     = busy_reg[l] && owner_reg[l] == req_reg.tid;
        t_owns   = busy_reg[l] && owner_reg[l] == crd_reg;
        full_l   = lcnt_reg[l] >= CW'(mcmu_pkg::MAX_THREADS);
        res_next = '0;
        res_next.last = 1'b1;
        more_next = 1'b0;
        lwr_en = 1'b0; lwr_addr = {l, ltail_reg[l]}; lwr_data = req_reg.tid;
        cwr_en = 1'b0; cwr_addr = {c, ctail_reg[c]}; cwr_data = req_reg.tid;
        lpop = 1'b0; cpop = 1'b0; do_rel = 1'b0; do_bind = 1'b0;
        do_unbind = 1'b0; set_busy = 1'b0;
        rel_hand = lcnt_reg[l] != '0;
        cnt_c_last = ccnt_reg[c] == CW'(1);
        case (req_reg.cmd)
            mcmu_pkg::CMD_ACQUIRE:
            begin
                if (owns)
                    res_next.status = mcmu_pkg::ST_HELD;
                else if (!busy_reg[l])
                begin
                    res_next.status = mcmu_pkg::ST_GRANTED;
                    set_busy = 1'b1;
                end
                else if (full_l)
                    res_next.status = mcmu_pkg::ST_FULL;
                else
                begin
                    res_next.status = mcmu_pkg::ST_BLOCKED;
                    lwr_en = 1'b1;
                end
            end
            mcmu_pkg::CMD_RELEASE:
            begin
                if (!owns)
                    res_next.status = mcmu_pkg::ST_NOTOWNER;
                else
                begin
                    res_next.status = mcmu_pkg::ST_DONE;
                    do_rel = 1'b1;
                end
            end
            mcmu_pkg::CMD_WAIT:
            begin
                if (!owns)
                    res_next.status = mcmu_pkg::ST_NOTOWNER;
                else if (bvalid_reg[c] && block_reg[c] != l)
                    res_next.status = mcmu_pkg::ST_MISMATCH;
                else if (ccnt_reg[c] >= CW'(mcmu_pkg::MAX_THREADS))
                    res_next.status = mcmu_pkg::ST_FULL;
                else
                begin
                    res_next.status = mcmu_pkg::ST_BLOCKED;
                    do_bind = 1'b1;
                    do_rel  = 1'b1;
                    cwr_en  = 1'b1;
                end
            end
            mcmu_pkg::CMD_SIGNAL, mcmu_pkg::CMD_BROADCAST:
            begin
                if (!owns)
                    res_next.status = mcmu_pkg::ST_NOTOWNER;
                else if (first_reg && ccnt_reg[c] == '0)
                    res_next.status = mcmu_pkg::ST_NONE;
                else if (!bvalid_reg[c] || block_reg[c] != l)
                    res_next.status = mcmu_pkg::ST_MISMATCH;
                else if (!t_owns && full_l)
                    res_next.status = mcmu_pkg::ST_FULL;
                else
                begin
                    res_next.status = mcmu_pkg::ST_DONE;
                    cpop = 1'b1;
                    lwr_en = !t_owns;
                    lwr_data = crd_reg;
                    do_unbind = cnt_c_last;
                    res_next.moved_valid = 1'b1;
                    res_next.moved_thread = crd_reg;
                    more_next = req_reg.cmd == mcmu_pkg::CMD_BROADCAST && !cnt_c_last;
                    res_next.last = !more_next;
                end
            end
            default:
                res_next.status = mcmu_pkg::ST_DONE;
        endcase
        if (do_rel && rel_hand)
        begin
            lpop = 1'b1;
            res_next.handed_valid = 1'b1;
            res_next.handed_thread = lrd_reg;
        end
        if (!cmd.exec)
        begin
            lwr_en = 1'b0; cwr_en = 1'b0; lpop = 1'b0; cpop = 1'b0;
            do_rel = 1'b0; do_bind = 1'b0; do_unbind = 1'b0; set_busy = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            bvalid_reg <= '0;
            first_reg  <= 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                owner_reg[i] <= '0;
                lhead_reg[i] <= '0;
                ltail_reg[i] <= '0;
                lcnt_reg[i]  <= '0;
            end
            for (int i = 0; i < NC; i++)
            begin
                chead_reg[i] <= '0;
                ctail_reg[i] <= '0;
                ccnt_reg[i]  <= '0;
                block_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
                first_reg <= 1'b1;
            else if (cmd.exec)
                first_reg <= 1'b0;
            if (set_busy)
            begin
                busy_reg[l]  <= 1'b1;
                owner_reg[l] <= req_reg.tid;
            end
            if (do_rel)
            begin
                if (rel_hand)
                    owner_reg[l] <= lrd_reg;
                else
                begin
                    busy_reg[l]  <= 1'b0;
                    owner_reg[l] <= '0;
                end
            end
            if (lpop)
                lhead_reg[l] <= lhead_reg[l] + PW'(1);
            if (lwr_en)
                ltail_reg[l] <= ltail_reg[l] + PW'(1);
            if (lwr_en && !lpop)
                lcnt_reg[l] <= lcnt_reg[l] + CW'(1);
            else if (lpop && !lwr_en)
                lcnt_reg[l] <= lcnt_reg[l] - CW'(1);
            if (cpop)
            begin
                chead_reg[c] <= chead_reg[c] + PW'(1);
                ccnt_reg[c]  <= ccnt_reg[c] - CW'(1);
            end
            if (cwr_en)
            begin
                ctail_reg[c] <= ctail_reg[c] + PW'(1);
                ccnt_reg[c]  <= ccnt_reg[c] + CW'(1);
            end
            if (do_bind)
            begin
                bvalid_reg[c] <= 1'b1;
                block_reg[c]  <= l;
            end
            if (do_unbind)
            begin
                bvalid_reg[c] <= 1'b0;
                block_reg[c]  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.exec)
            res_reg <= res_next;
    end

    assign stat.more = more_next;
    assign res = res_reg;

endmodule
`default_nettype wire

>>> hdl/mcmu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcmu_ctrl
// Sequencer: load, read queue heads, execute, present result, loop for broadcast.
// ----------------------------------------------------------------------------
module mcmu_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_fire,
    input  wire                  out_fire,
    input  mcmu_pkg::dp_stat_t   stat,
    output mcmu_pkg::dp_cmd_t    cmd,
    output logic                 in_rdy,
    output logic                 out_vld
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   more_reg, more_next;

    always_comb
    begin
        state_next = state_reg;
        more_next  = more_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_fire;
                if (in_fire)
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_EXEC;
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                more_next  = stat.more;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_fire)
                    state_next = more_reg ? S_EXEC : S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_rdy  = state_reg == S_IDLE;
    assign out_vld = state_reg == S_OUT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            more_reg  <= more_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/mutex_condition_monitor_unit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mutex_condition_monitor_unit_top
// Lock and condition-variable manager with FIFO waiter queues.
// ----------------------------------------------------------------------------
// channel | dir | tdata                              | tuser | tlast
// s_axis  | in  | cmd, thread_id, lock_index, cond_index | -  | -
// m_axis  | out | status, handed_*, moved_*          | -     | last
//
// A request's first result follows its input transfer through a read state,
// then an execute state; the input is taken again no earlier than the
// cycle after the last result transfer, so requests never overlap.
// Broadcast yields one result per moved waiter, each after a further execute
// state that follows the previous transfer. Output stalls hold the
// sequencer. Reset clears all lock and condition state at once.
// ----------------------------------------------------------------------------
module mutex_condition_monitor_unit_top
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // cmd[2:0] thread_id[6:3] lock_index[8:7]
                                       // cond_index[10:9], zeros
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status[2:0] handed_valid[3]
                                       // handed_thread[7:4] moved_valid[8]
                                       // moved_thread[12:9], zeros
    output logic        m_axis_tlast
);

    mcmu_pkg::req_t     req;
    mcmu_pkg::dp_cmd_t  cmd;
    mcmu_pkg::dp_stat_t stat;
    mcmu_pkg::res_t     res;
    logic               in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign req.cmd = s_axis_tdata[2:0];
    assign req.tid = s_axis_tdata[6:3];
    assign req.lck = s_axis_tdata[8:7];
    assign req.cnd = s_axis_tdata[10:9];

    mcmu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .stat     (stat),
        .cmd      (cmd),
        .in_rdy   (s_axis_tready),
        .out_vld  (m_axis_tvalid)
    );

    mcmu_datapath u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .res   (res)
    );

    assign m_axis_tdata = {3'b000, res.moved_thread, res.moved_valid,
                           res.handed_thread, res.handed_valid, res.status};
    assign m_axis_tlast = res.last;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    a_hand_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == mcmu_pkg::ST_DONE
        || m_axis_tdata[2:0] == mcmu_pkg::ST_BLOCKED)
        else $error("handoff with wrong status");
    a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[2:0] == mcmu_pkg::ST_DONE)
        else $error("move with wrong status");
`endif

endmodule
`default_nettype wire

>>> dv/mutex_condition_monitor_unit_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mutex_condition_monitor_unit_top_tb
// Drives lock, wait, signal and broadcast requests into the lock manager and
// checks every result transfer against a behavioral model of the lock state.
// ----------------------------------------------------------------------------
module mutex_condition_monitor_unit_top_tb;

    localparam int NRAND    = 80;
    localparam int WDOG_MAX = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    always #1 clk = ~clk;

    mutex_condition_monitor_unit_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // lock manager state mirror
    logic [3:0] busy;
    logic [3:0] owner    [mcmu_pkg::NUM_LOCKS];
    logic [3:0] lwait    [mcmu_pkg::NUM_LOCKS][mcmu_pkg::MAX_THREADS];
    int         lhead    [mcmu_pkg::NUM_LOCKS];
    int         ltail    [mcmu_pkg::NUM_LOCKS];
    int         lcount   [mcmu_pkg::NUM_LOCKS];
    logic [3:0] cwait    [mcmu_pkg::NUM_CONDS][mcmu_pkg::MAX_THREADS];
    int         chead    [mcmu_pkg::NUM_CONDS];
    int         ctail    [mcmu_pkg::NUM_CONDS];
    int         ccount   [mcmu_pkg::NUM_CONDS];
    logic [3:0] bound;
    logic [1:0] bound_lock [mcmu_pkg::NUM_CONDS];

    mcmu_pkg::res_t expected_results[$];
    int   fails = 0;
    int   idle_cycles = 0;
    bit   stim_done = 0;
    bit   hold_off = 0;
    bit   no_idle = 0;

    function automatic mcmu_pkg::res_t mk(logic [2:0] st, logic hv, logic [3:0] ht,
                                          logic mv, logic [3:0] mt, logic lst);
        mcmu_pkg::res_t r;
        r.status = st; r.handed_valid = hv; r.handed_thread = ht;
        r.moved_valid = mv; r.moved_thread = mt; r.last = lst;
        return r;
    endfunction

    function automatic bit holds(int l, logic [3:0] t);
        return busy[l] && owner[l] == t;
    endfunction

    task automatic lock_push(int l, logic [3:0] t);
        lwait[l][ltail[l]] = t;
        ltail[l] = (ltail[l] + 1) % mcmu_pkg::MAX_THREADS;
        lcount[l]++;
    endtask

    task automatic pass_lock(int l, output logic hv, output logic [3:0] ht);
        hv = 0; ht = 0;
        if (lcount[l] > 0) begin
            ht = lwait[l][lhead[l]];
            lhead[l] = (lhead[l] + 1) % mcmu_pkg::MAX_THREADS;
            lcount[l]--;
            owner[l] = ht;
            hv = 1;
        end else begin
            busy[l] = 0;
            owner[l] = 0;
        end
    endtask

    task automatic clear_locks();
        busy = '0; bound = '0;
        for (int i = 0; i < 4; i++) begin
            owner[i] = 0; lhead[i] = 0; ltail[i] = 0; lcount[i] = 0;
            chead[i] = 0; ctail[i] = 0; ccount[i] = 0; bound_lock[i] = 0;
        end
    endtask

    // computes the results of one request and updates the mirror
    task automatic grant_and_queue(mcmu_pkg::req_t q);
        int l, c, n;
        logic hv;
        logic [3:0] ht, t;
        logic [2:0] st;
        l = q.lck; c = q.cnd;
        case (q.cmd)
            mcmu_pkg::CMD_ACQUIRE:
                if (holds(l, q.tid))
                    expected_results.push_back(mk(mcmu_pkg::ST_HELD, 0, 0, 0, 0, 1));
                else if (!busy[l]) begin
                    busy[l] = 1; owner[l] = q.tid;
                    expected_results.push_back(mk(mcmu_pkg::ST_GRANTED, 0, 0, 0, 0, 1));
                end else if (lcount[l] >= mcmu_pkg::MAX_THREADS)
                    expected_results.push_back(mk(mcmu_pkg::ST_FULL, 0, 0, 0, 0, 1));
                else begin
                    lock_push(l, q.tid);
                    expected_results.push_back(mk(mcmu_pkg::ST_BLOCKED, 0, 0, 0, 0, 1));
                end
            mcmu_pkg::CMD_RELEASE:
                if (!holds(l, q.tid))
                    expected_results.push_back(mk(mcmu_pkg::ST_NOTOWNER, 0, 0, 0, 0, 1));
                else begin
                    pass_lock(l, hv, ht);
                    expected_results.push_back(mk(mcmu_pkg::ST_DONE, hv, ht, 0, 0, 1));
                end
            mcmu_pkg::CMD_WAIT:
                if (!holds(l, q.tid))
                    expected_results.push_back(mk(mcmu_pkg::ST_NOTOWNER, 0, 0, 0, 0, 1));
                else if (bound[c] && bound_lock[c] != l)
                    expected_results.push_back(mk(mcmu_pkg::ST_MISMATCH, 0, 0, 0, 0, 1));
                else if (ccount[c] >= mcmu_pkg::MAX_THREADS)
                    expected_results.push_back(mk(mcmu_pkg::ST_FULL, 0, 0, 0, 0, 1));
                else begin
                    bound[c] = 1; bound_lock[c] = 2'(l);
                    pass_lock(l, hv, ht);
                    cwait[c][ctail[c]] = q.tid;
                    ctail[c] = (ctail[c] + 1) % mcmu_pkg::MAX_THREADS;
                    ccount[c]++;
                    expected_results.push_back(mk(mcmu_pkg::ST_BLOCKED, hv, ht, 0, 0, 1));
                end
            mcmu_pkg::CMD_SIGNAL, mcmu_pkg::CMD_BROADCAST:
                if (!holds(l, q.tid))
                    expected_results.push_back(mk(mcmu_pkg::ST_NOTOWNER, 0, 0, 0, 0, 1));
                else if (ccount[c] == 0)
                    expected_results.push_back(mk(mcmu_pkg::ST_NONE, 0, 0, 0, 0, 1));
                else begin
                    n = 0;
                    do begin
                        st = mcmu_pkg::ST_DONE;
                        t = cwait[c][chead[c]];
                        if (!bound[c] || bound_lock[c] != l)
                            st = mcmu_pkg::ST_MISMATCH;
                        else if (!holds(l, t) && lcount[l] >= mcmu_pkg::MAX_THREADS)
                            st = mcmu_pkg::ST_FULL;
                        if (st != mcmu_pkg::ST_DONE) begin
                            expected_results.push_back(mk(st, 0, 0, 0, 0, 1));
                            break;
                        end
                        chead[c] = (chead[c] + 1) % mcmu_pkg::MAX_THREADS;
                        ccount[c]--;
                        if (!holds(l, t)) lock_push(l, t);
                        if (ccount[c] == 0) begin
                            bound[c] = 0; bound_lock[c] = 0;
                        end
                        n++;
                        expected_results.push_back(mk(mcmu_pkg::ST_DONE, 0, 0, 1, t,
                            (q.cmd == mcmu_pkg::CMD_SIGNAL || ccount[c] == 0)));
                    end while (q.cmd == mcmu_pkg::CMD_BROADCAST && ccount[c] > 0
                               && n < mcmu_pkg::MAX_THREADS);
                end
            default: expected_results.push_back(mk(mcmu_pkg::ST_DONE, 0, 0, 0, 0, 1));
        endcase
    endtask

    function automatic mcmu_pkg::req_t rq(logic [2:0] cmd, int t, int l, int c);
        mcmu_pkg::req_t q;
        q.cmd = cmd; q.tid = 4'(t); q.lck = 2'(l); q.cnd = 2'(c);
        return q;
    endfunction

    // sends one request; returns once the transfer is accepted, tvalid still high
    task automatic send(mcmu_pkg::req_t q);
        while (!no_idle && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, q.cnd, q.lck, q.tid, q.cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        grant_and_queue(q);
    endtask

    // random request with a bias toward owner-issued, well-formed sequences
    function automatic mcmu_pkg::req_t pick();
        int l, p, t;
        l = $urandom_range(3);
        p = $urandom_range(99);
        t = $urandom_range(15);
        if (busy[l] && p < 70) t = owner[l];
        if (p < 25) return rq(mcmu_pkg::CMD_ACQUIRE, t, l, $urandom_range(3));
        if (p < 40) return rq(mcmu_pkg::CMD_RELEASE, t, l, $urandom_range(3));
        if (p < 65) return rq(mcmu_pkg::CMD_WAIT, t, l, $urandom_range(3));
        if (p < 80) return rq(mcmu_pkg::CMD_SIGNAL, t, l, $urandom_range(3));
        if (p < 95) return rq(mcmu_pkg::CMD_BROADCAST, t, l, $urandom_range(3));
        return rq(3'($urandom_range(7)), t, l, $urandom_range(3));
    endfunction

    // directed table: typed expected status where obvious, else predictor only
    typedef struct {
        mcmu_pkg::req_t q;
        bit             typed;
        logic [2:0]     st;
    } row_t;

    row_t tbl[$];

    task automatic add(mcmu_pkg::req_t q, bit typed, logic [2:0] st);
        row_t r;
        r.q = q; r.typed = typed; r.st = st;
        tbl.push_back(r);
    endtask

    initial
    begin
        int n;
        clear_locks();
        add(rq(mcmu_pkg::CMD_RELEASE, 15, 3, 3), 1, mcmu_pkg::ST_NOTOWNER);
        add(rq(mcmu_pkg::CMD_SIGNAL, 0, 0, 0), 1, mcmu_pkg::ST_NOTOWNER);
        add(rq(mcmu_pkg::CMD_ACQUIRE, 0, 0, 0), 1, mcmu_pkg::ST_GRANTED);
        add(rq(mcmu_pkg::CMD_ACQUIRE, 0, 0, 0), 1, mcmu_pkg::ST_HELD);
        add(rq(mcmu_pkg::CMD_SIGNAL, 0, 0, 0), 1, mcmu_pkg::ST_NONE);
        add(rq(mcmu_pkg::CMD_BROADCAST, 0, 0, 3), 1, mcmu_pkg::ST_NONE);
        add(rq(mcmu_pkg::CMD_ACQUIRE, 15, 0, 0), 1, mcmu_pkg::ST_BLOCKED);
        add(rq(mcmu_pkg::CMD_ACQUIRE, 9, 0, 0), 1, mcmu_pkg::ST_BLOCKED);
        add(rq(mcmu_pkg::CMD_WAIT, 0, 0, 3), 0, 0);    // hands lock to thread 15
        add(rq(mcmu_pkg::CMD_WAIT, 15, 0, 3), 0, 0);
        add(rq(mcmu_pkg::CMD_ACQUIRE, 5, 3, 0), 1, mcmu_pkg::ST_GRANTED);
        add(rq(mcmu_pkg::CMD_WAIT, 5, 3, 3), 1, mcmu_pkg::ST_MISMATCH);
        add(rq(mcmu_pkg::CMD_SIGNAL, 5, 3, 3), 1, mcmu_pkg::ST_MISMATCH);
        add(rq(mcmu_pkg::CMD_BROADCAST, 9, 0, 3), 0, 0);
        add(rq(3'd5, 0, 0, 0), 1, mcmu_pkg::ST_DONE);
        add(rq(3'd7, 15, 3, 3), 1, mcmu_pkg::ST_DONE);
        add(rq(mcmu_pkg::CMD_RELEASE, 9, 0, 0), 0, 0);
        add(rq(mcmu_pkg::CMD_WAIT, 0, 0, 2), 0, 0);
        add(rq(mcmu_pkg::CMD_ACQUIRE, 0, 0, 2), 0, 0);
        add(rq(mcmu_pkg::CMD_SIGNAL, 15, 0, 2), 0, 0); // moved waiter may already own
        add(rq(mcmu_pkg::CMD_RELEASE, 5, 3, 0), 1, mcmu_pkg::ST_DONE);
        add(rq(3'd6, 10, 2, 1), 1, mcmu_pkg::ST_DONE);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (tbl[i])
        begin
            send(tbl[i].q);
            if (tbl[i].typed && expected_results[$].status != tbl[i].st)
            begin
                $error("table row %0d status expected %0d model %0d", i,
                       tbl[i].st, expected_results[$].status);
                fails++;
            end
        end
        for (n = 0; n < NRAND; n++)
        begin
            no_idle = (n >= 20 && n < 50);
            if (n == 60) hold_off = 1;
            send(pick());
        end
        // fill a lock queue and a condition queue to the full limit
        send(rq(mcmu_pkg::CMD_ACQUIRE, 1, 1, 1));
        for (n = 0; n < 18; n++) send(rq(mcmu_pkg::CMD_ACQUIRE, n, 1, 1));
        for (n = 0; n < 18; n++) send(rq(mcmu_pkg::CMD_WAIT, owner[1], 1, 1));
        send(rq(mcmu_pkg::CMD_BROADCAST, owner[1], 1, 1));
        for (n = 0; n < 20; n++) send(pick());
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                hold_off = 0;
                repeat (60) @(posedge clk);
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        mcmu_pkg::res_t e, a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a = mk(m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[7:4],
                   m_axis_tdata[8], m_axis_tdata[12:9], m_axis_tlast);
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fails++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (a.status != e.status) begin
                    $error("status expected %0d actual %0d", e.status, a.status); fails++; end
                if (a.handed_valid != e.handed_valid) begin
                    $error("handed_valid expected %0d actual %0d", e.handed_valid,
                           a.handed_valid); fails++; end
                if (a.handed_thread != e.handed_thread) begin
                    $error("handed_thread expected %0d actual %0d", e.handed_thread,
                           a.handed_thread); fails++; end
                if (a.moved_valid != e.moved_valid) begin
                    $error("moved_valid expected %0d actual %0d", e.moved_valid,
                           a.moved_valid); fails++; end
                if (a.moved_thread != e.moved_thread) begin
                    $error("moved_thread expected %0d actual %0d", e.moved_thread,
                           a.moved_thread); fails++; end
                if (a.last != e.last) begin
                    $error("last expected %0d actual %0d", e.last, a.last); fails++; end
            end
        end
    end

    // watchdog on cycles without any transfer, and end of run
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("Some tests failed");
                $finish;
            end
            else if (stim_done && expected_results.size() == 0)
            begin
                repeat (20) @(posedge clk);
                if (fails == 0 && expected_results.size() == 0)
                    $display("All tests passed");
                else
                    $display("Some tests failed");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
